### hw/rtl/jkiss_pkg.sv
// Shared types, constants and the xorshift step for the JKISS range generator.
`default_nettype none

package jkiss_pkg;

    localparam logic [31:0] LCG_MUL    = 32'd314527869;
    localparam logic [31:0] LCG_ADD    = 32'd1234567;
    localparam logic [31:0] MWC_MUL    = 32'd4294584393;
    localparam logic [31:0] LCG_INIT   = 32'd123456789;
    localparam logic [31:0] SHIFT_INIT = 32'd987654321;
    localparam logic [31:0] MWC_INIT   = 32'd43219876;
    localparam logic [31:0] CARRY_INIT = 32'd6543217;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_UPD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic seed_load;
        logic load_in;
        logic gen;
        logic upd;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic bounds_bad;
        logic div_last;
    } sts_t;

    function automatic logic [31:0] xorshift(input logic [31:0] w);
        logic [31:0] s;
        s = w;
        s = s ^ (s << 5);
        s = s ^ (s >> 7);
        s = s ^ (s << 22);
        return s;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/jkiss_random_range_generator.sv
// A request with valid bounds passes through the product step, the update step,
// 32 remainder steps and the output load before its result is offered.
// A new request is taken only once the previous result has been loaded, so requests do not overlap.
// Inverted bounds go from idle straight to the output load, generator untouched.
// Reset (aresetn low, synchronous) loads the generator as for a seed of zero.
// A seed write is taken only while no request is in flight.
`default_nettype none

module jkiss_random_range_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_lower_bound,
    input  wire logic [31:0] s_upper_bound,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_bounded_value,
    output logic [31:0]      m_raw_word,
    output logic             m_bounds_error,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_data
);

    jkiss_pkg::cmd_t cmd;
    jkiss_pkg::sts_t sts;

    jkiss_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    jkiss_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_data        (cfg_data),
        .s_lower_bound   (s_lower_bound),
        .s_upper_bound   (s_upper_bound),
        .m_bounded_value (m_bounded_value),
        .m_raw_word      (m_raw_word),
        .m_bounds_error  (m_bounds_error)
    );

endmodule

`default_nettype wire

### hw/rtl/jkiss_ctrl.sv
// Controller: sequences generator update, restoring division and result hand-off.
`default_nettype none

module jkiss_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire jkiss_pkg::sts_t sts,
    output jkiss_pkg::cmd_t      cmd
);

    jkiss_pkg::state_t state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            jkiss_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sts.bounds_bad ? jkiss_pkg::ST_DONE : jkiss_pkg::ST_GEN;
                end
            end
            jkiss_pkg::ST_GEN: state_next = jkiss_pkg::ST_UPD;
            jkiss_pkg::ST_UPD: state_next = jkiss_pkg::ST_DIV;
            jkiss_pkg::ST_DIV: begin
                if (sts.div_last) begin
                    state_next = jkiss_pkg::ST_DONE;
                end
            end
            jkiss_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = jkiss_pkg::ST_IDLE;
                end
            end
            default: state_next = jkiss_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            jkiss_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                cfg_ready     = 1'b1;
                cmd.load_in   = s_valid;
                cmd.seed_load = cfg_valid;
            end
            jkiss_pkg::ST_GEN:  cmd.gen      = 1'b1;
            jkiss_pkg::ST_UPD:  cmd.upd      = 1'b1;
            jkiss_pkg::ST_DIV:  cmd.div_step = 1'b1;
            jkiss_pkg::ST_DONE: cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= jkiss_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    // a finished result must never overwrite one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.out_load && m_valid_reg && !m_ready))
        else $error("result overwritten before transfer");

    a_bad_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && sts.bounds_bad) |=> state_reg == jkiss_pkg::ST_DONE)
        else $error("inverted bounds did not go straight to result");

    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == jkiss_pkg::ST_DIV && sts.div_last) |=> state_reg == jkiss_pkg::ST_DONE)
        else $error("division did not finish on last step");
`endif

endmodule

`default_nettype wire

### hw/rtl/jkiss_dp.sv
// Datapath: generator state, product registers, bit-serial modulo and result register.
`default_nettype none

module jkiss_dp (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire jkiss_pkg::cmd_t cmd,
    output jkiss_pkg::sts_t      sts,
    input  wire logic [63:0]     cfg_data,
    input  wire logic [31:0]     s_lower_bound,
    input  wire logic [31:0]     s_upper_bound,
    output logic [31:0]          m_bounded_value,
    output logic [31:0]          m_raw_word,
    output logic                 m_bounds_error
);

    logic [31:0] lcg_word_reg, lcg_word_next;
    logic [31:0] shift_word_reg, shift_word_next;
    logic [31:0] mwc_word_reg, mwc_word_next;
    logic [31:0] mwc_carry_reg, mwc_carry_next;

    logic [31:0] lcg_prod_reg;
    logic [63:0] mwc_prod_reg;

    logic [31:0] lower_reg;
    logic [32:0] span_reg;
    logic        err_reg;
    logic [31:0] raw_reg;
    logic [31:0] dividend_reg;
    logic [31:0] rem_reg;
    logic [jkiss_pkg::CNT_W-1:0] cnt_reg;

    logic [31:0] bounded_reg;
    logic [31:0] raw_out_reg;
    logic        err_out_reg;

    logic [31:0] lcg_new, mwc_new;
    logic [32:0] trial;
    logic [32:0] trial_diff;

    assign sts.bounds_bad = s_upper_bound < s_lower_bound;
    assign sts.div_last   = cnt_reg == jkiss_pkg::CNT_LAST;

    assign lcg_new = lcg_prod_reg + jkiss_pkg::LCG_ADD;
    assign mwc_new = mwc_prod_reg[31:0];

    // generator state: reloaded from seed, advanced over GEN/UPD
    always_comb begin
        lcg_word_next   = lcg_word_reg;
        shift_word_next = shift_word_reg;
        mwc_word_next   = mwc_word_reg;
        mwc_carry_next  = mwc_carry_reg;
        priority if (cmd.seed_load) begin
            lcg_word_next   = jkiss_pkg::LCG_INIT + cfg_data[31:0];
            shift_word_next = jkiss_pkg::SHIFT_INIT + cfg_data[63:32];
            mwc_word_next   = jkiss_pkg::MWC_INIT;
            mwc_carry_next  = jkiss_pkg::CARRY_INIT;
        end else if (cmd.gen) begin
            shift_word_next = jkiss_pkg::xorshift(shift_word_reg);
        end else if (cmd.upd) begin
            lcg_word_next  = lcg_new;
            mwc_word_next  = mwc_new;
            mwc_carry_next = mwc_prod_reg[63:32];
        end else begin
            // state held
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_word_reg   <= jkiss_pkg::LCG_INIT;
            shift_word_reg <= jkiss_pkg::SHIFT_INIT;
            mwc_word_reg   <= jkiss_pkg::MWC_INIT;
            mwc_carry_reg  <= jkiss_pkg::CARRY_INIT;
        end else begin
            lcg_word_reg   <= lcg_word_next;
            shift_word_reg <= shift_word_next;
            mwc_word_reg   <= mwc_word_next;
            mwc_carry_reg  <= mwc_carry_next;
        end
    end

    // products registered before they are used
    always_ff @(posedge aclk) begin
        if (cmd.gen) begin
            lcg_prod_reg <= jkiss_pkg::LCG_MUL * lcg_word_reg;
            mwc_prod_reg <= 64'(jkiss_pkg::MWC_MUL) * 64'(mwc_word_reg)
                            + 64'(mwc_carry_reg);
        end
    end

    // restoring division: one quotient bit per cycle, only remainder kept
    assign trial      = {rem_reg, dividend_reg[31]};
    assign trial_diff = trial - span_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            lower_reg <= s_lower_bound;
            span_reg  <= {1'b0, s_upper_bound} - {1'b0, s_lower_bound} + 33'd1;
            err_reg   <= sts.bounds_bad;
        end
        if (cmd.upd) begin
            raw_reg      <= lcg_new + shift_word_reg + mwc_new;
            dividend_reg <= lcg_new + shift_word_reg + mwc_new;
            rem_reg      <= '0;
            cnt_reg      <= '0;
        end else if (cmd.div_step) begin
            dividend_reg <= {dividend_reg[30:0], 1'b0};
            rem_reg      <= (trial >= span_reg) ? trial_diff[31:0] : trial[31:0];
            cnt_reg      <= cnt_reg + 1'b1;
        end
        if (cmd.out_load) begin
            bounded_reg <= err_reg ? 32'd0 : rem_reg + lower_reg;
            raw_out_reg <= err_reg ? 32'd0 : raw_reg;
            err_out_reg <= err_reg;
        end
    end

    assign m_bounded_value = bounded_reg;
    assign m_raw_word      = raw_out_reg;
    assign m_bounds_error  = err_out_reg;

`ifndef SYNTHESIS
    a_rem_below_span: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |=> {1'b0, rem_reg} < span_reg)
        else $error("partial remainder not below span");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && err_reg) |=> (m_bounded_value == 32'd0 && m_raw_word == 32'd0
                                      && m_bounds_error))
        else $error("error result not zeroed");

    a_span_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> span_reg == {1'b0, $past(s_upper_bound)}
                                    - {1'b0, $past(s_lower_bound)} + 33'd1)
        else $error("span latched wrongly");
`endif

endmodule

`default_nettype wire

### sim/jkiss_random_range_generator_test.sv
// Self-checking testbench for the JKISS bounded random number generator.
`default_nettype none

module jkiss_random_range_generator_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] bounded_value;
        logic [31:0] raw_word;
        logic        bounds_error;
    } draw_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_lower_bound;
    logic [31:0] s_upper_bound;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_bounded_value;
    logic [31:0] m_raw_word;
    logic        m_bounds_error;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;

    // generator copy held by the testbench
    logic [31:0] gen_lcg;
    logic [31:0] gen_shift;
    logic [31:0] gen_mwc;
    logic [31:0] gen_carry;

    draw_t expected_draws[$];
    int    mismatches = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    hold_cycles = 0;

    jkiss_random_range_generator uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_lower_bound   (s_lower_bound),
        .s_upper_bound   (s_upper_bound),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bounded_value (m_bounded_value),
        .m_raw_word      (m_raw_word),
        .m_bounds_error  (m_bounds_error),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic void load_generator(logic [63:0] seed);
        gen_lcg   = jkiss_pkg::LCG_INIT + seed[31:0];
        gen_shift = jkiss_pkg::SHIFT_INIT + seed[63:32];
        gen_mwc   = jkiss_pkg::MWC_INIT;
        gen_carry = jkiss_pkg::CARRY_INIT;
    endfunction

    function automatic draw_t predict_draw(logic [31:0] lo, logic [31:0] hi);
        draw_t       d;
        logic [31:0] s;
        logic [63:0] prod;
        logic [63:0] span;
        logic [31:0] raw;
        if (hi < lo) begin
            d.bounded_value = '0;
            d.raw_word      = '0;
            d.bounds_error  = 1'b1;
            return d;
        end
        gen_lcg = jkiss_pkg::LCG_MUL * gen_lcg + jkiss_pkg::LCG_ADD;
        s = gen_shift;
        s = s ^ (s << 5);
        s = s ^ (s >> 7);
        s = s ^ (s << 22);
        gen_shift = s;
        prod = 64'(jkiss_pkg::MWC_MUL) * 64'(gen_mwc) + 64'(gen_carry);
        gen_carry = prod[63:32];
        gen_mwc   = prod[31:0];
        raw = gen_lcg + gen_shift + gen_mwc;
        // span needs 33 bits: the full range gives 2^32
        span = 64'(hi) - 64'(lo) + 64'd1;
        d.bounded_value = 32'((64'(raw) % span) + 64'(lo));
        d.raw_word      = raw;
        d.bounds_error  = 1'b0;
        return d;
    endfunction

    // result side: ready driven at the falling edge, long hold-off counted here
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        draw_t exp_d;
        if (aresetn && m_valid && m_ready) begin
            if (expected_draws.size() == 0) begin
                $error("unexpected result transfer: bounded_value %0h raw_word %0h",
                       m_bounded_value, m_raw_word);
                mismatches++;
            end else begin
                exp_d = expected_draws.pop_front();
                if (m_bounded_value !== exp_d.bounded_value) begin
                    $error("bounded_value: expected %0h, actual %0h",
                           exp_d.bounded_value, m_bounded_value);
                    mismatches++;
                end
                if (m_raw_word !== exp_d.raw_word) begin
                    $error("raw_word: expected %0h, actual %0h",
                           exp_d.raw_word, m_raw_word);
                    mismatches++;
                end
                if (m_bounds_error !== exp_d.bounds_error) begin
                    $error("bounds_error: expected %0b, actual %0b",
                           exp_d.bounds_error, m_bounds_error);
                    mismatches++;
                end
            end
        end
    end

    // valid is left high after the transfer so that requests can run back to back
    task automatic send_bounds(logic [31:0] lo, logic [31:0] hi);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_lower_bound = lo;
        s_upper_bound = hi;
        do @(posedge aclk); while (!s_ready);
        expected_draws.push_back(predict_draw(lo, hi));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_draws.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_seed(logic [63:0] seed);
        drain_results();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = seed;
        do @(posedge aclk); while (!cfg_ready);
        load_generator(seed);
        @(negedge aclk);
        cfg_valid = 1'b0;
        cfg_data  = {$urandom, $urandom};
    endtask

    task automatic pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(9))
            0: begin
                // inverted bounds
                if (a == b) b = a ^ 32'd1;
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            1: begin
                lo = a;
                hi = a;
            end
            2: begin
                lo = '0;
                hi = '1;
            end
            3: begin
                lo = a;
                hi = a + 32'($urandom_range(15));
                if (hi < lo) hi = '1;
            end
            4: begin
                lo = '0;
                hi = b;
            end
            5: begin
                lo = a;
                hi = '1;
            end
            default: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        endcase
    endtask

    task automatic test_directed_bounds();
        send_bounds(32'h0000_0000, 32'hFFFF_FFFF);
        send_bounds(32'h0000_0000, 32'h0000_0000);
        send_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bounds(32'h0000_0005, 32'h0000_0005);
        send_bounds(32'h0000_0001, 32'h0000_0000);
        send_bounds(32'hFFFF_FFFF, 32'h0000_0000);
        send_bounds(32'h8000_0000, 32'h7FFF_FFFF);
        send_bounds(32'h0000_0000, 32'h0000_0001);
        send_bounds(32'h0000_000A, 32'h0000_0014);
        send_bounds(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_bounds(32'h0000_0001, 32'hFFFF_FFFF);
        send_bounds(32'h0000_0000, 32'hFFFF_FFFE);
        send_bounds(32'h8000_0000, 32'hFFFF_FFFF);
        send_bounds(32'h0000_0000, 32'h7FFF_FFFF);
        send_bounds(32'h5555_5555, 32'hAAAA_AAAA);
        send_bounds(32'hAAAA_AAAA, 32'h5555_5555);
        send_bounds(32'h0000_0000, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_seed_settings();
        logic [63:0] seeds[5];
        logic [31:0] lo;
        logic [31:0] hi;
        seeds = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
                  64'h0000_0000_FFFF_FFFF, {$urandom, $urandom}};
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            repeat (4) begin
                pick_bounds(lo, hi);
                send_bounds(lo, hi);
            end
            send_bounds(32'h0, 32'hFFFF_FFFF);
        end
        drain_results();
    endtask

    task automatic test_output_stall();
        logic [31:0] lo;
        logic [31:0] hi;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_bounds(32'h0, 32'hFFFF_FFFF);
        // results back up while requests keep coming
        hold_cycles = 600;
        repeat (12) begin
            pick_bounds(lo, hi);
            send_bounds(lo, hi);
        end
        drain_results();
    endtask

    task automatic test_random_requests(int count, int sender_idle, int receiver_idle);
        logic [31:0] lo;
        logic [31:0] hi;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        write_seed({$urandom, $urandom});
        repeat (count) begin
            pick_bounds(lo, hi);
            send_bounds(lo, hi);
        end
        drain_results();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_lower_bound = '0;
        s_upper_bound = '0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        load_generator(64'h0);
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        test_directed_bounds();
        test_seed_settings();
        test_output_stall();
        test_random_requests(470, 6, 81);
        test_random_requests(470, 81, 6);
        test_random_requests(470, 0, 0);
        write_seed(64'h0);
        send_bounds(32'h0, 32'hFFFF_FFFF);
        drain_results();

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
